/* rtl/gmt_pkg.sv */
// ----------------------------------------------------------------------------
// gmt_pkg: shared types and constants of the group membership table
// Opcodes, status codes, field widths and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package gmt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int GROUP_BITS_DEF  = 16;
    localparam int UNIT_BITS_DEF   = 8;

    localparam int FUNC_W   = 3;
    localparam int GID_W    = 16;
    localparam int UID_W    = 8;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 3'd0,
        FN_REMOVE = 3'd1,
        FN_CLEAR  = 3'd2,
        FN_QUERY  = 3'd3,
        FN_LIST   = 3'd4
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        EM_NONE  = 2'd0,
        EM_PEND  = 2'd1,
        EM_FINAL = 2'd2
    } t_emit;

    // controller -> datapath
    typedef struct packed {
        logic    in_rdy;
        logic    rd_en;
        logic    rd_next;
        logic    wr_en;
        logic    wr_shift;
        logic    idx_inc;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    cnt_clr;
        logic    set_status;
        t_status status;
        logic    set_found;
        logic    pend_load;
        t_emit   emit;
    } t_gmt_cmd;

    // datapath -> controller
    typedef struct packed {
        logic              in_valid;
        logic [FUNC_W-1:0] func;
        logic              cnt_zero;
        logic              cnt_full;
        logic              idx_last;
        logic              shift_more;
        logic              key_match;
        logic              grp_match;
        logic              pend_vld;
        logic              slot_free;
    } t_gmt_sts;

endpackage

/* rtl/gmt_ifs.sv */
// ----------------------------------------------------------------------------
// gmt channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gmt_in_if;
    import gmt_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [GID_W-1:0]  group_id;
    logic [UID_W-1:0]  unit_id;

    modport source (output valid, output func, output group_id, output unit_id,
                    input ready);
    modport sink   (input valid, input func, input group_id, input unit_id,
                    output ready);
endinterface

interface gmt_out_if;
    import gmt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                found;
    logic                entry_valid;
    logic [GID_W-1:0]    out_group;
    logic [UID_W-1:0]    out_unit;
    logic [TOTAL_W-1:0]  entry_total;
    logic                last;

    modport source (output valid, output status, output found, output entry_valid,
                    output out_group, output out_unit, output entry_total,
                    output last, input ready);
    modport sink   (input valid, input status, input found, input entry_valid,
                    input out_group, input out_unit, input entry_total,
                    input last, output ready);
endinterface

/* rtl/group_membership_table.sv */
// ----------------------------------------------------------------------------
// group_membership_table: ordered set of unique (group, unit) pairs
// Insert, remove, clear, query and list over a compacted pair store.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one request item (func, group_id, unit_id); o_out carries
//   result items. Every request gives one result with last set, except list,
//   which gives one result per matching entry in stored order, the final one
//   with last set (one empty result if nothing matches).
//   A request is taken only while the sequencer is idle; one item at a time.
//   Clear and unused opcodes go straight to the result. Insert and query
//   scan the stored entries up to the pair, or all of them when it is absent;
//   remove searches up to the match, then moves each entry behind it down;
//   list scans the whole table. Each entry is read through the single
//   registered read port of the store, then compared or written back.
//   The next request can be taken in the cycle after the final result is
//   loaded.
//   The result sits in an output register; a new request may be taken while
//   it waits. When the receiver stalls, the sequencer holds before the next
//   result and the store is left untouched.
//   Reset empties the table (count cleared); no memory sweep is needed
//   because only entries below the count are ever read.
// ----------------------------------------------------------------------------
module group_membership_table #(
    parameter int TABLE_DEPTH = gmt_pkg::TABLE_DEPTH_DEF,
    parameter int GROUP_BITS  = gmt_pkg::GROUP_BITS_DEF,
    parameter int UNIT_BITS   = gmt_pkg::UNIT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gmt_in_if.sink    i_in,
    gmt_out_if.source o_out
);
    import gmt_pkg::*;

    t_gmt_cmd cmd;
    t_gmt_sts sts;

    gmt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    gmt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .GROUP_BITS  (GROUP_BITS),
        .UNIT_BITS   (UNIT_BITS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

/* rtl/gmt_datapath.sv */
// ----------------------------------------------------------------------------
// gmt_datapath: entry memory, counters and result register
// Holds the pair store, the entry count, scan index and the output stage.
// ----------------------------------------------------------------------------
module gmt_datapath #(
    parameter int TABLE_DEPTH = gmt_pkg::TABLE_DEPTH_DEF,
    parameter int GROUP_BITS  = gmt_pkg::GROUP_BITS_DEF,
    parameter int UNIT_BITS   = gmt_pkg::UNIT_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gmt_pkg::t_gmt_cmd i_cmd,
    output gmt_pkg::t_gmt_sts o_sts,
    gmt_in_if.sink           i_in,
    gmt_out_if.source        o_out
);
    import gmt_pkg::*;

    localparam int EW = GROUP_BITS + UNIT_BITS;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [EW-1:0]         r_mem [TABLE_DEPTH];
    logic [EW-1:0]         r_rd_data;
    logic [FUNC_W-1:0]     r_func;
    logic [GROUP_BITS-1:0] r_group;
    logic [UNIT_BITS-1:0]  r_unit;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_idx;
    t_status               r_status;
    logic                  r_found;
    logic                  r_pend_vld;
    logic [UNIT_BITS-1:0]  r_pend_unit;

    logic                  r_o_valid;
    logic [STATUS_W-1:0]   r_o_status;
    logic                  r_o_found;
    logic                  r_o_entry_valid;
    logic [GID_W-1:0]      r_o_group;
    logic [UID_W-1:0]      r_o_unit;
    logic [TOTAL_W-1:0]    r_o_total;
    logic                  r_o_last;

    logic                  accept;
    logic [CW:0]           idx_nxt;
    logic [CW-1:0]         rd_addr;
    logic [CW-1:0]         wr_addr;
    logic [EW-1:0]         wr_data;
    logic                  slot_free;

    assign accept    = i_cmd.in_rdy & i_in.valid;
    assign idx_nxt   = {1'b0, r_idx} + 1'b1;
    assign slot_free = !r_o_valid || o_out.ready;
    assign rd_addr   = i_cmd.rd_next ? idx_nxt[CW-1:0] : r_idx;
    assign wr_addr   = i_cmd.wr_shift ? r_idx : r_count;
    assign wr_data   = i_cmd.wr_shift ? r_rd_data : {r_group, r_unit};

    assign i_in.ready = i_cmd.in_rdy;

    assign o_sts.in_valid   = i_in.valid;
    assign o_sts.func       = r_func;
    assign o_sts.cnt_zero   = (r_count == '0);
    assign o_sts.cnt_full   = ({1'b0, r_count} == (CW + 1)'(TABLE_DEPTH));
    assign o_sts.idx_last   = (idx_nxt == {1'b0, r_count});
    assign o_sts.shift_more = (idx_nxt < {1'b0, r_count});
    assign o_sts.key_match  = (r_rd_data == {r_group, r_unit});
    assign o_sts.grp_match  = (r_rd_data[EW-1:UNIT_BITS] == r_group);
    assign o_sts.pend_vld   = r_pend_vld;
    assign o_sts.slot_free  = slot_free;

    // pair store, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr[AW-1:0]];
        end
    end

    // item registers and pending list entry
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_in.func;
            r_group <= i_in.group_id[GROUP_BITS-1:0];
            r_unit  <= i_in.unit_id[UNIT_BITS-1:0];
        end
        if (i_cmd.pend_load) begin
            r_pend_unit <= r_rd_data[UNIT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_idx      <= '0;
            r_status   <= ST_OK;
            r_found    <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_idx      <= '0;
                r_status   <= ST_OK;
                r_found    <= 1'b0;
                r_pend_vld <= 1'b0;
            end else begin
                if (i_cmd.idx_inc) begin
                    r_idx <= idx_nxt[CW-1:0];
                end
                if (i_cmd.set_status) begin
                    r_status <= i_cmd.status;
                end
                if (i_cmd.set_found) begin
                    r_found <= 1'b1;
                end
                if (i_cmd.pend_load) begin
                    r_pend_vld <= 1'b1;
                end
            end
            if (i_cmd.cnt_clr) begin
                r_count <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit != EM_NONE) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.emit)
            EM_PEND: begin
                r_o_status      <= ST_OK;
                r_o_found       <= 1'b0;
                r_o_entry_valid <= 1'b1;
                r_o_group       <= GID_W'(r_group);
                r_o_unit        <= UID_W'(r_pend_unit);
                r_o_total       <= TOTAL_W'(r_count);
                r_o_last        <= 1'b0;
            end
            EM_FINAL: begin
                r_o_total <= TOTAL_W'(r_count);
                r_o_last  <= 1'b1;
                if (r_func == FN_LIST) begin
                    r_o_status      <= ST_OK;
                    r_o_found       <= 1'b0;
                    r_o_entry_valid <= r_pend_vld;
                    r_o_group       <= r_pend_vld ? GID_W'(r_group) : '0;
                    r_o_unit        <= r_pend_vld ? UID_W'(r_pend_unit) : '0;
                end else begin
                    r_o_status      <= r_status;
                    r_o_found       <= r_found;
                    r_o_entry_valid <= 1'b0;
                    r_o_group       <= '0;
                    r_o_unit        <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.status      = r_o_status;
    assign o_out.found       = r_o_found;
    assign o_out.entry_valid = r_o_entry_valid;
    assign o_out.out_group   = r_o_group;
    assign o_out.out_unit    = r_o_unit;
    assign o_out.entry_total = r_o_total;
    assign o_out.last        = r_o_last;

endmodule

/* rtl/gmt_ctrl.sv */
// ----------------------------------------------------------------------------
// gmt_ctrl: operation sequencer
// Walks the store one entry at a time for search, compaction and listing.
// ----------------------------------------------------------------------------
module gmt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gmt_pkg::t_gmt_sts i_sts,
    output gmt_pkg::t_gmt_cmd o_cmd
);
    import gmt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_READ,
        S_CHECK,
        S_END,
        S_SH_READ,
        S_SH_WRITE,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_rdy = 1'b1;
                if (i_sts.in_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_sts.func)
                    FN_CLEAR: begin
                        o_cmd.cnt_clr = 1'b1;
                        n_state       = S_FINISH;
                    end
                    FN_INSERT, FN_REMOVE, FN_QUERY, FN_LIST: begin
                        n_state = i_sts.cnt_zero ? S_END : S_READ;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.func == FN_LIST) begin
                    // hold the read entry until the previous match can go out
                    if (!(i_sts.grp_match && i_sts.pend_vld && !i_sts.slot_free)) begin
                        if (i_sts.grp_match) begin
                            o_cmd.pend_load = 1'b1;
                            if (i_sts.pend_vld) begin
                                o_cmd.emit = EM_PEND;
                            end
                        end
                        if (i_sts.idx_last) begin
                            n_state = S_FINISH;
                        end else begin
                            o_cmd.idx_inc = 1'b1;
                            n_state       = S_READ;
                        end
                    end
                end else if (i_sts.key_match) begin
                    if (i_sts.func == FN_REMOVE) begin
                        n_state = S_SH_READ;
                    end else begin
                        o_cmd.set_found = (i_sts.func == FN_QUERY);
                        n_state         = S_FINISH;
                    end
                end else if (i_sts.idx_last) begin
                    n_state = S_END;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_END: begin
                // pair absent after a full scan, or table empty
                if (i_sts.func == FN_INSERT) begin
                    if (i_sts.cnt_full) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_FULL;
                    end else begin
                        o_cmd.wr_en   = 1'b1;
                        o_cmd.cnt_inc = 1'b1;
                    end
                end else if (i_sts.func == FN_REMOVE) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NOT_FOUND;
                end
                n_state = S_FINISH;
            end
            S_SH_READ: begin
                if (i_sts.shift_more) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_next = 1'b1;
                    n_state       = S_SH_WRITE;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_FINISH;
                end
            end
            S_SH_WRITE: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state        = S_SH_READ;
            end
            S_FINISH: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit = EM_FINAL;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/gmt_checker.sv */
// ----------------------------------------------------------------------------
// gmt_checker: port-level checks for the group membership table
// Watches the request and result channels over time.
// ----------------------------------------------------------------------------
module gmt_checker #(
    parameter int TABLE_DEPTH = gmt_pkg::TABLE_DEPTH_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [gmt_pkg::STATUS_W-1:0] i_status,
    input logic                         i_found,
    input logic                         i_entry_valid,
    input logic [gmt_pkg::TOTAL_W-1:0]  i_entry_total,
    input logic                         i_last
);
    import gmt_pkg::*;

    // one item at a time: no request taken right after another
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken back to back");

    // only listing gives results that are not last
    a_not_last_is_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> i_entry_valid && i_status == ST_OK && !i_found)
        else $error("non-final result is not a list entry");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (TABLE_DEPTH >= 32) || (int'(i_entry_total) <= TABLE_DEPTH))
        else $error("entry total exceeds table depth");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_last)
            && $stable(i_entry_total) && $stable(i_status))
        else $error("stalled result changed");

endmodule

bind group_membership_table gmt_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_gmt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_status      (o_out.status),
    .i_found       (o_out.found),
    .i_entry_valid (o_out.entry_valid),
    .i_entry_total (o_out.entry_total),
    .i_last        (o_out.last)
);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: group membership table
// Sends insert, remove, clear, query, list and unused-opcode requests, with random gaps on
// the request side and random back-pressure on the result side. A class keeps
// its own copy of the pair table and checks each result item in order.
// ----------------------------------------------------------------------------
module testbench;
    import gmt_pkg::*;

    localparam int DEPTH          = TABLE_DEPTH_DEF;
    localparam int FUNC_MAX       = (1 << FUNC_W) - 1;
    localparam int REPORT_LIMIT   = 10;
    localparam int DRAIN_CYCLES   = 4 * DEPTH + 40;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [GID_W-1:0] grp;
        logic [UID_W-1:0] unit;
    } t_member;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic                entry_valid;
        logic [GID_W-1:0]    grp;
        logic [UID_W-1:0]    unit;
        logic [TOTAL_W-1:0]  total;
        logic                last;
    } t_result;

    class membership_model;
        t_member pair_store [DEPTH];
        int      pair_count;
        t_result expected_results [$];
        int      error_count;

        function string describe(t_result r);
            return $sformatf("status %0d found %0b valid %0b group %h unit %h total %0d last %0b",
                             r.status, r.found, r.entry_valid, r.grp, r.unit, r.total, r.last);
        endfunction

        function void add_expected(t_result r);
            expected_results.insert(expected_results.size(), r);
        endfunction

        // existing pair most of the time, so removes and queries hit
        function t_member pick_member(t_member fallback);
            if (pair_count == 0 || $urandom_range(3) == 0)
                return fallback;
            return pair_store[$urandom_range(pair_count - 1)];
        endfunction

        function void apply_request(logic [FUNC_W-1:0] func, logic [GID_W-1:0] grp,
                                    logic [UID_W-1:0] unit);
            t_result r;
            int      pos;
            int      last_hit;
            r        = '0;
            r.last   = 1'b1;
            pos      = -1;
            last_hit = -1;
            for (int i = 0; i < pair_count; i++) begin
                if (pos < 0 && pair_store[i] == {grp, unit})
                    pos = i;
                if (pair_store[i].grp == grp)
                    last_hit = i;
            end
            case (func)
                FN_INSERT: begin
                    if (pos < 0) begin
                        if (pair_count >= DEPTH) begin
                            r.status = ST_FULL;
                        end else begin
                            pair_store[pair_count] = {grp, unit};
                            pair_count++;
                        end
                    end
                end
                FN_REMOVE: begin
                    if (pos < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        for (int i = pos; i < pair_count - 1; i++)
                            pair_store[i] = pair_store[i + 1];
                        pair_count--;
                    end
                end
                FN_CLEAR: pair_count = 0;
                FN_QUERY: r.found = (pos >= 0);
                FN_LIST: begin
                    if (last_hit >= 0) begin
                        for (int i = 0; i <= last_hit; i++) begin
                            if (pair_store[i].grp == grp) begin
                                r.entry_valid = 1'b1;
                                r.grp         = pair_store[i].grp;
                                r.unit        = pair_store[i].unit;
                                r.total       = TOTAL_W'(pair_count);
                                r.last        = (i == last_hit);
                                add_expected(r);
                            end
                        end
                        return;
                    end
                end
                default: ;
            endcase
            r.total = TOTAL_W'(pair_count);
            add_expected(r);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected result item: %s", describe(got));
                return;
            end
            want = expected_results.pop_front();
            if (got !== want) begin
                error_count++;
                if (error_count <= REPORT_LIMIT) begin
                    $display("result mismatch");
                    $display("  expected: %s", describe(want));
                    $display("  actual:   %s", describe(got));
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   send_idle_pct;
    int   stall_pct;
    int   quiet_cycles = 0;

    membership_model table_model;

    gmt_in_if  req_ch ();
    gmt_out_if rsp_ch ();

    group_membership_table DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_ch.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            table_model.check_result({rsp_ch.status, rsp_ch.found, rsp_ch.entry_valid,
                                      rsp_ch.out_group, rsp_ch.out_unit,
                                      rsp_ch.entry_total, rsp_ch.last});
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(logic [FUNC_W-1:0] func, logic [GID_W-1:0] grp,
                                logic [UID_W-1:0] unit);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid    = 1'b1;
        req_ch.func     = func;
        req_ch.group_id = grp;
        req_ch.unit_id  = unit;
        do
            @(posedge i_clk);
        while (!req_ch.ready);
        table_model.apply_request(func, grp, unit);
        @(negedge i_clk);
    endtask

    // small pools of groups and units so that duplicates, hits and a full
    // table come up often
    task automatic run_mixed(int n_items);
        logic [GID_W-1:0] group_pool [4];
        logic [UID_W-1:0] unit_pool [6];
        logic [GID_W-1:0] g;
        logic [UID_W-1:0] u;
        t_member          m;
        int               pick;
        foreach (group_pool[i]) group_pool[i] = GID_W'($urandom);
        foreach (unit_pool[i]) unit_pool[i] = UID_W'($urandom);
        repeat (n_items) begin
            pick = $urandom_range(99);
            g    = group_pool[$urandom_range(3)];
            u    = unit_pool[$urandom_range(5)];
            m    = table_model.pick_member({g, u});
            if (pick < 36)
                send_request(FN_INSERT, g, u);
            else if (pick < 56)
                send_request(FN_REMOVE, m.grp, m.unit);
            else if (pick < 70)
                send_request(FN_QUERY, m.grp, m.unit);
            else if (pick < 90)
                send_request(FN_LIST, m.grp, UID_W'($urandom));
            else if (pick < 94)
                send_request(FN_CLEAR, GID_W'($urandom), UID_W'($urandom));
            else if (pick < 97)
                send_request(FUNC_W'($urandom_range(FN_LIST + 1, FUNC_MAX)),
                             GID_W'($urandom), UID_W'($urandom));
            else
                send_request(FUNC_W'($urandom_range(FN_LIST)), GID_W'($urandom),
                             UID_W'($urandom));
        end
    endtask

    initial begin
        logic [GID_W-1:0] fill_group;
        logic [UID_W-1:0] fill_unit;
        table_model     = new;
        send_idle_pct   = 0;
        stall_pct       = 0;
        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.func     = FN_INSERT;
        req_ch.group_id = '0;
        req_ch.unit_id  = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table: listing gives one empty item, remove misses
        send_request(FN_LIST, '0, '0);
        send_request(FN_REMOVE, '0, '0);
        send_request(FN_INSERT, '0, '0);
        send_request(FN_INSERT, '1, '1);
        send_request(FN_INSERT, '0, '0);
        send_request(FN_QUERY, '1, '1);
        for (int i = 0; i < DEPTH - 2; i++)
            send_request(FN_INSERT, (i % 2) ? 16'hAAAA : 16'h5555, UID_W'(8'hA5 ^ i));
        send_request(FN_INSERT, 16'h1234, 8'h56);
        send_request(FN_LIST, 16'h5555, '0);
        // first entry out, everything behind it moves down
        send_request(FN_REMOVE, '0, '0);
        send_request(FN_QUERY, '0, '0);
        send_request(FUNC_W'(FUNC_MAX), '1, '1);
        send_request(FN_CLEAR, '1, '1);
        send_request(FN_LIST, '1, '0);

        run_mixed(20);

        send_idle_pct = 80;
        stall_pct     = 0;
        run_mixed(25);

        // one group filling the whole table, then the longest listing
        send_idle_pct = 0;
        stall_pct     = 80;
        fill_group    = GID_W'($urandom);
        fill_unit     = UID_W'($urandom);
        send_request(FN_CLEAR, '0, '0);
        for (int i = 0; i < DEPTH; i++)
            send_request(FN_INSERT, fill_group, fill_unit + UID_W'(i));
        send_request(FN_LIST, fill_group, '0);
        run_mixed(12);

        send_idle_pct = 26;
        stall_pct     = 26;
        run_mixed(28);

        req_ch.valid = 1'b0;
        while (table_model.expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (table_model.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
